// ===== hdl/hsvrgb_pkg.sv =====
// Shared types and constants for the HSV to RGB percent converter.
package hsvrgb_pkg;

   // One input item: hue in degrees, saturation and value in percent.
   typedef struct packed {
      logic [8:0] hue;
      logic [6:0] saturation;
      logic [6:0] brightness;
   } req_type;

   // One result item: truncated 8-bit channel levels.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // Register stages between the request and response ports.
   localparam int STAGES = 6;

endpackage

// ===== hdl/hsv_to_rgb_percent_unit.sv =====
// HSV (degrees, percent) to 8-bit RGB conversion pipeline.
//
//   channel  ports                          direction  item
//   -------  -----------------------------  ---------  ---------------------------------
//   request  req_valid, req_ready, req_data  in         hue 0..359, saturation, brightness
//   response rsp_valid, rsp_ready, rsp_data  out        red, green, blue levels
//
// One item enters per clock while req_ready is high. Each result passes through
// the six register stages before it leaves.
// Reset clears every stage valid bit; payload registers are not reset.
// A stall on the response side holds the last stage; empty stages ahead of it keep
// filling, so req_ready drops only when all six stages hold items.
//
// Arithmetic: with K in units of 1/6000 of full scale,
//   level = floor(v * 255 * K / 600000) = floor(v * 17 * K / 40000),
// and the division by 40000 is a shift by 6 followed by division by 625,
// done as a reciprocal multiply with a one-step correction.
module hsv_to_rgb_percent_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hsvrgb_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output hsvrgb_pkg::rsp_type rsp_data
);

   localparam int NST             = hsvrgb_pkg::STAGES;
   localparam int HUE_W           = 9;
   localparam int HUE_SECTOR      = 60;
   localparam int SEXT_MAX        = ((1 << HUE_W) - 1) / HUE_SECTOR;
   localparam int PCT_MAX         = 100;
   localparam int FULL_K          = PCT_MAX * HUE_SECTOR;
   localparam int LEVEL_NUM       = 17;
   localparam int LEVEL_DEN_SHIFT = 6;
   localparam int LEVEL_DEN_ODD   = 625;
   localparam int RECIP_SHIFT     = 24;
   localparam int RECIP           = (1 << RECIP_SHIFT) / LEVEL_DEN_ODD;

   // Sextant codes; anything above the red-rising sextant maps to blue falling.
   localparam logic [3:0] SEXT_GREEN_RISE = 4'd0;
   localparam logic [3:0] SEXT_RED_FALL   = 4'd1;
   localparam logic [3:0] SEXT_BLUE_RISE  = 4'd2;
   localparam logic [3:0] SEXT_GREEN_FALL = 4'd3;
   localparam logic [3:0] SEXT_RED_RISE   = 4'd4;

   // Count the sector boundaries at or below the hue.
   function automatic logic [3:0] hue_sextant(input logic [HUE_W-1:0] hue);
      logic [3:0] sext;
      sext = '0;
      for (int i = 1; i <= SEXT_MAX; i++) begin
         if (hue >= HUE_W'(i * HUE_SECTOR)) begin
            sext = sext + 4'd1;
         end
      end
      return sext;
   endfunction

   // ---------------- handshake: per-stage valid and load enable ----------------
   logic valid_ff [NST];
   logic load     [NST];

   always_comb begin
      load[NST-1] = !valid_ff[NST-1] || rsp_ready;
      for (int i = NST - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   assign req_ready = load[0];
   assign rsp_valid = valid_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (load[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NST; i++) begin
            if (load[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // ---------------- stage 1: clamp percents, split hue into sextant and offset -
   logic [6:0] s1_sat_in, s1_val_in;
   logic [3:0] s1_sext_in;
   logic [5:0] s1_frac_in;
   logic [6:0] s1_sat_ff, s1_val_ff;
   logic [3:0] s1_sext_ff;
   logic [5:0] s1_frac_ff;

   always_comb begin
      s1_sat_in  = (req_data.saturation > 7'(PCT_MAX)) ? 7'(PCT_MAX) : req_data.saturation;
      s1_val_in  = (req_data.brightness > 7'(PCT_MAX)) ? 7'(PCT_MAX) : req_data.brightness;
      s1_sext_in = hue_sextant(req_data.hue);
      s1_frac_in = 6'(req_data.hue - HUE_W'(s1_sext_in) * HUE_W'(HUE_SECTOR));
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_sat_ff  <= s1_sat_in;
         s1_val_ff  <= s1_val_in;
         s1_sext_ff <= s1_sext_in;
         s1_frac_ff <= s1_frac_in;
      end
   end

   // ---------------- stage 2: minimum term, ramp term, scaled value -------------
   logic [12:0] s2_lo_in, s2_ramp_in;
   logic [10:0] s2_v17_in;
   logic [12:0] s2_lo_ff, s2_ramp_ff;
   logic [10:0] s2_v17_ff;
   logic [3:0]  s2_sext_ff;

   always_comb begin
      s2_lo_in   = 13'(7'(PCT_MAX) - s1_sat_ff) * 13'(HUE_SECTOR);
      s2_ramp_in = 13'(s1_sat_ff) * 13'(s1_frac_ff);
      s2_v17_in  = 11'(s1_val_ff) * 11'(LEVEL_NUM);
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s2_lo_ff   <= s2_lo_in;
         s2_ramp_ff <= s2_ramp_in;
         s2_v17_ff  <= s2_v17_in;
         s2_sext_ff <= s1_sext_ff;
      end
   end

   // ---------------- stage 3: pick max, min or ramp per channel -----------------
   // Lane order: red, green, blue.
   logic [12:0] s3_k_in [3];
   logic [12:0] s3_k_ff [3];
   logic [10:0] s3_v17_ff;
   logic [12:0] lo_up, hi_down, full;

   always_comb begin
      full    = 13'(FULL_K);
      lo_up   = s2_lo_ff + s2_ramp_ff;
      hi_down = full - s2_ramp_ff;
      unique case (s2_sext_ff)
         SEXT_GREEN_RISE: begin
            s3_k_in[0] = full;    s3_k_in[1] = lo_up;   s3_k_in[2] = s2_lo_ff;
         end
         SEXT_RED_FALL: begin
            s3_k_in[0] = hi_down; s3_k_in[1] = full;    s3_k_in[2] = s2_lo_ff;
         end
         SEXT_BLUE_RISE: begin
            s3_k_in[0] = s2_lo_ff; s3_k_in[1] = full;   s3_k_in[2] = lo_up;
         end
         SEXT_GREEN_FALL: begin
            s3_k_in[0] = s2_lo_ff; s3_k_in[1] = hi_down; s3_k_in[2] = full;
         end
         SEXT_RED_RISE: begin
            s3_k_in[0] = lo_up;   s3_k_in[1] = s2_lo_ff; s3_k_in[2] = full;
         end
         default: begin
            s3_k_in[0] = full;    s3_k_in[1] = s2_lo_ff; s3_k_in[2] = hi_down;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         s3_k_ff   <= s3_k_in;
         s3_v17_ff <= s2_v17_ff;
      end
   end

   // ---------------- stage 4: scale by value, drop the power-of-two divisor -----
   logic [23:0] s4_prod [3];
   logic [17:0] s4_y_in [3];
   logic [17:0] s4_y_ff [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s4_prod[c] = 24'(s3_v17_ff) * 24'(s3_k_ff[c]);
         s4_y_in[c] = 18'(s4_prod[c] >> LEVEL_DEN_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         s4_y_ff <= s4_y_in;
      end
   end

   // ---------------- stage 5: reciprocal estimate of y / 625 --------------------
   logic [32:0] s5_prod [3];
   logic [8:0]  s5_q_in [3];
   logic [8:0]  s5_q_ff [3];
   logic [17:0] s5_y_ff [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s5_prod[c] = 33'(s4_y_ff[c]) * 33'(RECIP);
         s5_q_in[c] = 9'(s5_prod[c] >> RECIP_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         s5_q_ff <= s5_q_in;
         s5_y_ff <= s4_y_ff;
      end
   end

   // ---------------- stage 6: correct the estimate by at most one ---------------
   logic [17:0] s6_rem [3];
   logic [8:0]  s6_q   [3];
   hsvrgb_pkg::rsp_type s6_rsp_in, s6_rsp_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s6_rem[c] = s5_y_ff[c] - 18'(s5_q_ff[c]) * 18'(LEVEL_DEN_ODD);
         s6_q[c]   = s5_q_ff[c] + 9'(s6_rem[c] >= 18'(LEVEL_DEN_ODD));
      end
      s6_rsp_in.red   = 8'(s6_q[0]);
      s6_rsp_in.green = 8'(s6_q[1]);
      s6_rsp_in.blue  = 8'(s6_q[2]);
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         s6_rsp_ff <= s6_rsp_in;
      end
   end

   assign rsp_data = s6_rsp_ff;

endmodule

// ===== hdl/hsvrgb_checker.sv =====
// Port-level checker for the HSV to RGB converter, bound to the top level.
module hsvrgb_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input hsvrgb_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input hsvrgb_pkg::rsp_type rsp_data
);

   localparam int NST = hsvrgb_pkg::STAGES;

   // Track items accepted but not yet delivered.
   logic [$clog2(NST+1)-1:0] count_ff, count_in;
   logic                     req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (req_fire && !rsp_fire) begin
         count_in = count_ff + 1'b1;
      end else if (!req_fire && rsp_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // Empty the pipeline on reset.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Never show a result with nothing in flight.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != '0)
      else $error("result with no item in flight");

   // Drop request ready only when every stage is occupied.
   a_full_only: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> count_ff == ($bits(count_ff))'(NST))
      else $error("request stalled with free stages");

endmodule

bind hsv_to_rgb_percent_unit hsvrgb_checker u_hsvrgb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
